[rtl/ppab_pkg.sv]
package ppab_pkg;

  localparam int unsigned DIV_BITS  = 40;
  localparam int unsigned STG_ASM   = 0;
  localparam int unsigned STG_EXT   = 1;
  localparam int unsigned STG_NUM   = 2;
  localparam int unsigned STG_DIV0  = 3;
  localparam int unsigned STG_MIX   = STG_DIV0 + DIV_BITS;
  localparam int unsigned STG_SCALE = STG_MIX + 1;
  localparam int unsigned STG_REQ   = STG_MIX + 2;
  localparam int unsigned STG_RECIP = STG_MIX + 3;
  localparam int unsigned STG_PACK  = STG_MIX + 4;
  localparam int unsigned STG_OUT   = STG_MIX + 5;
  localparam int unsigned NSTAGE    = STG_OUT + 1;

  localparam logic [2:0] REG_RED_MASK   = 3'd0;
  localparam logic [2:0] REG_GREEN_MASK = 3'd1;
  localparam logic [2:0] REG_BLUE_MASK  = 3'd2;
  localparam logic [2:0] REG_SHIFTS     = 3'd3;
  localparam logic [2:0] REG_MAXIMA     = 3'd4;
  localparam logic [2:0] REG_PIX_BYTES  = 3'd5;
  localparam logic [2:0] REG_MSB_FIRST  = 3'd6;

  localparam logic [31:0] RST_RED_MASK   = 32'h00ff_0000;
  localparam logic [31:0] RST_GREEN_MASK = 32'h0000_ff00;
  localparam logic [31:0] RST_BLUE_MASK  = 32'h0000_00ff;
  localparam logic [14:0] RST_SHIFTS     = 15'd272;
  localparam logic [47:0] RST_MAXIMA     = 48'h00ff_00ff_00ff;
  localparam logic [2:0]  RST_PIX_BYTES  = 3'd4;

  // ceil(2^31 / 255); exact quotient for numerators below 2^31 / 127
  localparam logic [23:0] RECIP_255 = 24'h80_8081;
  localparam int unsigned RECIP_SHIFT = 31;

  typedef struct packed {
    logic [2:0][31:0] mask;
    logic [2:0][4:0]  shift;
    logic [2:0][15:0] maxv;
    logic [2:0]       nbytes;
    logic             msb;
  } cfg_t;

  typedef struct packed {
    logic [31:0]      dest;
    logic [31:0]      word;
    logic [7:0]       a;
    logic [2:0][7:0]  src;
    logic [2:0][47:0] acc;
    logic [2:0][15:0] rem;
    logic [2:0][7:0]  quo;
  } item_t;

  function automatic logic [2:0] byte_count(input logic [2:0] n);
    case (n)
      3'd2, 3'd3, 3'd4: byte_count = n;
      default: byte_count = 3'd1;
    endcase
  endfunction

  function automatic logic [31:0] low_mask(input logic [2:0] n);
    case (n)
      3'd2: low_mask = 32'h0000_ffff;
      3'd3: low_mask = 32'h00ff_ffff;
      3'd4: low_mask = 32'hffff_ffff;
      default: low_mask = 32'h0000_00ff;
    endcase
  endfunction

  // byte i goes to byte n-1-i when msb first; its own inverse
  function automatic logic [31:0] assemble(input logic [31:0] b, input logic [2:0] n,
                                           input logic msb);
    case (n)
      3'd2: assemble = msb ? {16'h0, b[7:0], b[15:8]} : {16'h0, b[15:0]};
      3'd3: assemble = msb ? {8'h0, b[7:0], b[15:8], b[23:16]} : {8'h0, b[23:0]};
      3'd4: assemble = msb ? {b[7:0], b[15:8], b[23:16], b[31:24]} : b;
      default: assemble = {24'h0, b[7:0]};
    endcase
  endfunction

  function automatic item_t step(input int unsigned k, input item_t x, input cfg_t c);
    item_t       y;
    logic [16:0] t;
    logic [7:0]  d;
    logic [15:0] q;
    logic [23:0] p;
    logic [2:0]  n;
    y = x;
    n = byte_count(c.nbytes);
    if (k == STG_ASM) begin
      y.word = assemble(x.dest, n, c.msb);
    end else if (k == STG_EXT) begin
      for (int ch = 0; ch < 3; ch++) begin
        y.acc[ch] = 48'((x.word & c.mask[ch]) >> c.shift[ch]);
      end
    end else if (k == STG_NUM) begin
      for (int ch = 0; ch < 3; ch++) begin
        y.acc[ch] = (x.acc[ch] << 8) - x.acc[ch] + 48'(c.maxv[ch] >> 1);
        y.rem[ch] = '0;
        y.quo[ch] = '0;
      end
    end else if (k >= STG_DIV0 && k < STG_MIX) begin
      // one restoring step, quotient MSB first, low 8 bits kept
      for (int ch = 0; ch < 3; ch++) begin
        t = {x.rem[ch], x.acc[ch][DIV_BITS-1]};
        y.acc[ch] = x.acc[ch] << 1;
        if (t >= {1'b0, c.maxv[ch]}) begin
          y.rem[ch] = 16'(t - {1'b0, c.maxv[ch]});
          y.quo[ch] = {x.quo[ch][6:0], 1'b1};
        end else begin
          y.rem[ch] = t[15:0];
          y.quo[ch] = {x.quo[ch][6:0], 1'b0};
        end
      end
    end else if (k == STG_MIX) begin
      for (int ch = 0; ch < 3; ch++) begin
        d = (c.maxv[ch] == 16'h0) ? 8'h0 : x.quo[ch];
        y.acc[ch] = 48'(16'(x.src[ch]) * 16'(x.a)) + 48'(16'(d) * 16'(8'hff - x.a))
                  + 48'd127;
      end
    end else if (k == STG_SCALE) begin
      // x / 255 for x below 2^16 - 1
      for (int ch = 0; ch < 3; ch++) begin
        y.acc[ch] = (x.acc[ch] + (x.acc[ch] >> 8) + 48'd1) >> 8;
      end
    end else if (k == STG_REQ) begin
      for (int ch = 0; ch < 3; ch++) begin
        p = 24'(x.acc[ch][7:0]) * 24'(c.maxv[ch]) + 24'd127;
        y.acc[ch] = 48'(p);
      end
    end else if (k == STG_RECIP) begin
      for (int ch = 0; ch < 3; ch++) begin
        y.acc[ch] = 48'(x.acc[ch][23:0]) * 48'(RECIP_255);
      end
    end else if (k == STG_PACK) begin
      y.word = '0;
      for (int ch = 0; ch < 3; ch++) begin
        q = x.acc[ch][RECIP_SHIFT +: 16];
        y.word = y.word | (({16'h0, q} << c.shift[ch]) & c.mask[ch]);
      end
    end else if (k == STG_OUT) begin
      y.word = assemble(x.word, n, c.msb) | (x.dest & ~low_mask(n));
    end
    return y;
  endfunction

endpackage

[rtl/packed_pixel_alpha_blend_top.sv]
// Channel   Dir  Width  Content (low bit up)
// s_*       in   64     dest_bytes 31:0, source_red 39:32, source_green 47:40,
//                       source_blue 55:48, opacity 63:56
// m_*       out  32     blended_bytes 31:0
// cfg_*     in   48     register write, index 0..6, higher indexes ignored
//
// One beat per cycle unless backpressure stalls the pipeline, which holds the 40-step restoring
// divider that expands each destination channel to 8 bits.
// rst clears the stage valid bits and loads the register defaults.
// A stage loads whenever it or any later stage holds a bubble or the output
// is taken, so bubbles close up under backpressure.
module packed_pixel_alpha_blend_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // dest_bytes, source_red, source_green, source_blue, opacity
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // blended_bytes
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int unsigned NS = ppab_pkg::NSTAGE;

  ppab_pkg::cfg_t  cfg;
  ppab_pkg::item_t in_item;
  ppab_pkg::item_t stg [NS];
  logic [NS-1:0]   vld;
  logic [NS-1:0]   rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mask[0] <= ppab_pkg::RST_RED_MASK;
      cfg.mask[1] <= ppab_pkg::RST_GREEN_MASK;
      cfg.mask[2] <= ppab_pkg::RST_BLUE_MASK;
      cfg.shift   <= ppab_pkg::RST_SHIFTS;
      cfg.maxv    <= ppab_pkg::RST_MAXIMA;
      cfg.nbytes  <= ppab_pkg::RST_PIX_BYTES;
      cfg.msb     <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        ppab_pkg::REG_RED_MASK:   cfg.mask[0] <= cfg_data[31:0];
        ppab_pkg::REG_GREEN_MASK: cfg.mask[1] <= cfg_data[31:0];
        ppab_pkg::REG_BLUE_MASK:  cfg.mask[2] <= cfg_data[31:0];
        ppab_pkg::REG_SHIFTS:     cfg.shift   <= cfg_data[14:0];
        ppab_pkg::REG_MAXIMA:     cfg.maxv    <= cfg_data;
        ppab_pkg::REG_PIX_BYTES:  cfg.nbytes  <= cfg_data[2:0];
        ppab_pkg::REG_MSB_FIRST:  cfg.msb     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_item        = '0;
    in_item.dest   = s_tdata[31:0];
    in_item.src[0] = s_tdata[39:32];
    in_item.src[1] = s_tdata[47:40];
    in_item.src[2] = s_tdata[55:48];
    in_item.a      = s_tdata[63:56];
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    ppab_pkg::item_t prev;
    logic            prev_vld;

    assign rdy[k] = m_tready | ~(&vld[NS-1:k]);

    if (k == 0) begin : g_first
      assign prev     = in_item;
      assign prev_vld = s_tvalid;
    end else begin : g_rest
      assign prev     = stg[k-1];
      assign prev_vld = vld[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= prev_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        stg[k] <= ppab_pkg::step(k, prev, cfg);
      end
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[NS-1];
  assign m_tdata  = stg[NS-1].word;

endmodule

[tb/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_UNUSED = 3'd7;

  // packed as on s_tdata: dest, red, green, blue, opacity from the low bit up
  typedef struct packed {
    logic [7:0]      opacity;
    logic [2:0][7:0] src;
    logic [31:0]     dest;
  } pixel_t;

  typedef struct packed {
    logic [2:0][31:0] field_mask;
    logic [2:0][4:0]  field_shift;
    logic [2:0][15:0] field_max;
    logic [2:0]       pix_bytes;
    logic             msb_first;
  } fmt_regs_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  fmt_regs_t     fmt;
  pixel_t        pixel_queue[$];
  logic [31:0]   writeback_q[$];
  pixel_t        cur_pixel;
  logic [31:0]   want_word;
  int unsigned   pixels_queued = 0;
  int unsigned   writebacks_seen = 0;
  int unsigned   error_count = 0;
  int unsigned   burst_left = 0;
  int unsigned   gap_left = 0;
  int unsigned   stall_left = 0;
  int unsigned   rx_run = 0;
  int unsigned   rx_mode = 0;
  bit            long_hold_req = 1'b0;

  packed_pixel_alpha_blend_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic logic [31:0] predict_writeback(input pixel_t p);
    logic [31:0] word;
    logic [31:0] packed_word;
    logic [31:0] stored;
    logic [31:0] low;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] q;
    logic [31:0] a;
    logic [63:0] v;
    logic [63:0] mx;
    int unsigned n;
    word = '0;
    packed_word = '0;
    stored = '0;
    a = 32'(p.opacity);
    case (fmt.pix_bytes)
      3'd2, 3'd3, 3'd4: n = 32'(fmt.pix_bytes);
      default: n = 1;
    endcase
    for (int i = 0; i < n; i++) begin
      if (fmt.msb_first) word = {word[23:0], p.dest[8*i +: 8]};
      else word[8*i +: 8] = p.dest[8*i +: 8];
    end
    for (int ch = 0; ch < 3; ch++) begin
      c = 32'(p.src[ch]);
      mx = 64'(fmt.field_max[ch]);
      if (p.opacity != 8'hff) begin
        if (mx == 64'd0) begin
          d = '0;
        end else begin
          v = 64'((word & fmt.field_mask[ch]) >> fmt.field_shift[ch]);
          v = (v * 64'd255 + mx / 64'd2) / mx;
          d = {24'h0, v[7:0]};
        end
        c = (c * a + d * (32'd255 - a) + 32'd127) / 32'd255;
      end
      q = (c * 32'(fmt.field_max[ch]) + 32'd127) / 32'd255;
      packed_word = packed_word | ((q << fmt.field_shift[ch]) & fmt.field_mask[ch]);
    end
    for (int i = 0; i < n; i++) begin
      if (fmt.msb_first) stored[8*i +: 8] = packed_word[8*(n-1-i) +: 8];
      else stored[8*i +: 8] = packed_word[8*i +: 8];
    end
    low = (n == 4) ? 32'hffff_ffff : ((32'd1 << (8*n)) - 32'd1);
    return (p.dest & ~low) | stored;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t      p;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    p.dest = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hffff_ffff : 32'($urandom);
    for (int ch = 0; ch < 3; ch++) begin
      pick = $urandom_range(0, 7);
      p.src[ch] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hff : 8'($urandom);
    end
    pick = $urandom_range(0, 7);
    p.opacity = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hff : 8'($urandom);
    return p;
  endfunction

  task automatic queue_pixel(input pixel_t p);
    pixel_queue.push_back(p);
    pixels_queued++;
  endtask

  task automatic await_writebacks();
    while (writebacks_seen < pixels_queued) @(posedge clk);
  endtask

  task automatic blend_phase(input int count, input bit hold);
    for (int k = 0; k < count; k++) queue_pixel(random_pixel());
    if (hold) long_hold_req = 1'b1;
    await_writebacks();
    repeat (8) @(posedge clk);
  endtask

  // called at a rising edge with the pipeline empty
  task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      ppab_pkg::REG_RED_MASK:   fmt.field_mask[0] = val[31:0];
      ppab_pkg::REG_GREEN_MASK: fmt.field_mask[1] = val[31:0];
      ppab_pkg::REG_BLUE_MASK:  fmt.field_mask[2] = val[31:0];
      ppab_pkg::REG_SHIFTS:     fmt.field_shift = val[14:0];
      ppab_pkg::REG_MAXIMA:     fmt.field_max = val[47:0];
      ppab_pkg::REG_PIX_BYTES:  fmt.pix_bytes = val[2:0];
      ppab_pkg::REG_MSB_FIRST:  fmt.msb_first = val[0];
      default: ;
    endcase
  endtask

  task automatic set_format(input logic [47:0] red_m, input logic [47:0] green_m,
                            input logic [47:0] blue_m, input logic [47:0] shifts,
                            input logic [47:0] maxima, input logic [47:0] nbytes,
                            input logic [47:0] msb);
    write_reg(ppab_pkg::REG_RED_MASK, red_m);
    write_reg(ppab_pkg::REG_GREEN_MASK, green_m);
    write_reg(ppab_pkg::REG_BLUE_MASK, blue_m);
    write_reg(ppab_pkg::REG_SHIFTS, shifts);
    write_reg(ppab_pkg::REG_MAXIMA, maxima);
    write_reg(ppab_pkg::REG_PIX_BYTES, nbytes);
    write_reg(ppab_pkg::REG_MSB_FIRST, msb);
    cfg_write <= 1'b0;
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

  // sender: bursts of beats with gaps between them
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) writeback_q.push_back(predict_writeback(cur_pixel));
      if (!(s_tvalid && !s_tready)) begin
        if (gap_left != 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pixel_queue.size() != 0) begin
          cur_pixel = pixel_queue.pop_front();
          s_tdata <= cur_pixel;
          s_tvalid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 60);
            if ($urandom_range(0, 9) < 4) gap_left = 0;
            else if ($urandom_range(0, 9) == 0) gap_left = $urandom_range(10, 30);
            else gap_left = $urandom_range(1, 4);
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: runs of differing readiness, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      stall_left = 300;
      m_tready <= 1'b0;
    end else begin
      if (rx_run == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_run = $urandom_range(5, 80);
      end else begin
        rx_run--;
      end
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= !m_tready;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      writebacks_seen++;
      if (writeback_q.size() == 0) begin
        $error("unexpected beat: blended_bytes actual %h", m_tdata);
        error_count++;
      end else begin
        want_word = writeback_q.pop_front();
        if (m_tdata !== want_word) begin
          $error("blended_bytes mismatch: expected %h, actual %h", want_word, m_tdata);
          error_count++;
        end
      end
    end
  end

  initial begin
    int unsigned w_r;
    int unsigned w_g;
    int unsigned w_b;
    fmt = {ppab_pkg::RST_BLUE_MASK, ppab_pkg::RST_GREEN_MASK, ppab_pkg::RST_RED_MASK,
           ppab_pkg::RST_SHIFTS, ppab_pkg::RST_MAXIMA, ppab_pkg::RST_PIX_BYTES, 1'b0};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // opacity, blue, green, red, dest
    queue_pixel({8'h00, 8'hff, 8'hff, 8'hff, 32'h0000_0000});
    queue_pixel({8'h00, 8'h00, 8'h00, 8'h00, 32'hffff_ffff});
    queue_pixel({8'hff, 8'h00, 8'h00, 8'h00, 32'hffff_ffff});
    queue_pixel({8'hff, 8'hff, 8'hff, 8'hff, 32'h0000_0000});
    queue_pixel({8'h01, 8'hff, 8'h80, 8'h00, 32'hffff_ffff});
    queue_pixel({8'hfe, 8'h00, 8'h7f, 8'hff, 32'h0000_0000});
    queue_pixel({8'h80, 8'hff, 8'h00, 8'hff, 32'ha5a5_a5a5});
    queue_pixel({8'h7f, 8'h00, 8'hff, 8'h00, 32'h5a5a_5a5a});
    queue_pixel({8'h00, 8'h12, 8'h34, 8'h56, 32'hff00_ff00});
    queue_pixel({8'hff, 8'hab, 8'hcd, 8'hef, 32'h00ff_00ff});
    queue_pixel({8'h40, 8'h01, 8'h02, 8'h03, 32'h8000_0001});
    queue_pixel({8'hc0, 8'hfe, 8'hfd, 8'hfc, 32'h7fff_fffe});
    queue_pixel({8'h01, 8'h00, 8'h00, 8'h00, 32'h0000_0000});
    queue_pixel({8'hfe, 8'hff, 8'hff, 8'hff, 32'hffff_ffff});
    queue_pixel({8'h80, 8'h80, 8'h80, 8'h80, 32'h8080_8080});
    queue_pixel({8'h00, 8'hff, 8'h00, 8'hff, 32'h1234_5678});
    await_writebacks();
    repeat (8) @(posedge clk);

    // out-of-range index must leave the defaults alone
    write_reg(REG_UNUSED, '1);
    cfg_write <= 1'b0;
    blend_phase(200, 1'b1);

    // rgb565, both byte orders
    set_format(48'h00f800, 48'h0007e0, 48'h00001f, 48'({5'd0, 5'd5, 5'd11}),
               {16'd31, 16'd63, 16'd31}, 48'd2, 48'd0);
    blend_phase(35, 1'b0);
    write_reg(ppab_pkg::REG_MSB_FIRST, 48'd1);
    cfg_write <= 1'b0;
    blend_phase(35, 1'b0);
    // rgb888 in three bytes, msb first
    set_format(48'hff0000, 48'h00ff00, 48'h0000ff, 48'({5'd0, 5'd8, 5'd16}),
               {16'd255, 16'd255, 16'd255}, 48'd3, 48'd1);
    blend_phase(35, 1'b0);
    // rgb332 with a pixel size that falls back to one byte
    set_format(48'h0000e0, 48'h00001c, 48'h000003, 48'({5'd0, 5'd2, 5'd5}),
               {16'd3, 16'd7, 16'd7}, 48'd0, 48'd0);
    blend_phase(35, 1'b0);
    set_format(48'h000007, 48'h000038, 48'h0000c0, 48'({5'd6, 5'd3, 5'd0}),
               {16'd3, 16'd7, 16'd7}, 48'd1, 48'd1);
    blend_phase(35, 1'b0);
    set_format('0, '0, '0, '0, '0, 48'd5, 48'd1);
    blend_phase(35, 1'b0);
    set_format('1, '1, '1, '1, '1, '1, '1);
    blend_phase(35, 1'b0);
    // huge extracted red, zero green max, odd blue field
    set_format(48'hffff_ffff, 48'h0000_ffff, 48'hffff_ff00, 48'({5'd8, 5'd0, 5'd0}),
               {16'd3, 16'd0, 16'd1}, 48'd4, 48'd0);
    blend_phase(35, 1'b0);
    set_format(48'h00ff0000, 48'h0000ff00, 48'h000000ff, 48'({5'd0, 5'd31, 5'd16}),
               {16'hffff, 16'hffff, 16'd255}, 48'd4, 48'd1);
    blend_phase(35, 1'b0);

    for (int ph = 0; ph < 7; ph++) begin
      if (ph % 2 == 0) begin
        w_r = $urandom_range(1, 10);
        w_g = $urandom_range(1, 10);
        w_b = $urandom_range(1, 10);
        set_format(((48'd1 << w_r) - 48'd1) << (w_g + w_b),
                   ((48'd1 << w_g) - 48'd1) << w_b,
                   (48'd1 << w_b) - 48'd1,
                   48'({5'd0, 5'(w_b), 5'(w_g + w_b)}),
                   {16'((1 << w_b) - 1), 16'((1 << w_g) - 1), 16'((1 << w_r) - 1)},
                   48'($urandom_range(0, 7)), 48'($urandom_range(0, 1)));
      end else begin
        set_format(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                   48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                   48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                   48'({$urandom, $urandom}));
      end
      blend_phase((ph == 6) ? 200 : 35, ph == 6);
    end

    await_writebacks();
    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
